FILE: hdl/stx_pkg.sv
package stx_pkg;

	localparam int FIFO_DEPTH = 4;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [2:0] {
		EV_OPEN      = 3'd0,
		EV_CLOSE     = 3'd1,
		EV_DOT       = 3'd2,
		EV_ATOM_BYTE = 3'd3,
		EV_ATOM_END  = 3'd4,
		EV_STR_BYTE  = 3'd5,
		EV_STR_END   = 3'd6
	} ev_kind_t;

	typedef enum logic [3:0] {
		MODE_IDLE    = 4'b0001,
		MODE_ATOM    = 4'b0010,
		MODE_STRING  = 4'b0100,
		MODE_COMMENT = 4'b1000
	} scan_mode_t;

	typedef struct packed {
		scan_mode_t mode;
		logic       dot;
		logic       bs;
	} scan_state_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic [7:0] data;
		logic       last;
	} event_t;

	typedef struct packed {
		logic [1:0] cnt;
		event_t     ev0;
		event_t     ev1;
	} event_pair_t;

endpackage

FILE: hdl/stx_scan.sv
module stx_scan (
	input  logic [7:0]           ch,
	input  stx_pkg::scan_state_t cur,
	output stx_pkg::scan_state_t nxt,
	output stx_pkg::event_pair_t evs
);
	import stx_pkg::*;

	function automatic event_t mk_ev(input ev_kind_t kind, input logic [7:0] data);
		event_t e;
		e.kind = kind;
		e.data = data;
		e.last = 1'b0;
		return e;
	endfunction

	logic        is_blank;
	logic        is_paren;
	logic        idle_hit;
	event_t      idle_ev;
	scan_state_t idle_st;

	// handling of a byte between tokens with no dot held
	always_comb begin
		is_blank = ch inside {CH_SPACE, CH_TAB, CH_NL};
		is_paren = ch inside {CH_LPAREN, CH_RPAREN};
		idle_hit = 1'b0;
		idle_ev  = mk_ev(EV_OPEN, CH_NUL);
		idle_st.mode = MODE_IDLE;
		idle_st.dot  = 1'b0;
		idle_st.bs   = cur.bs;
		if (is_blank) begin
			idle_hit = 1'b0;
		end else if (ch == CH_LPAREN) begin
			idle_hit = 1'b1;
			idle_ev  = mk_ev(EV_OPEN, CH_NUL);
		end else if (ch == CH_RPAREN) begin
			idle_hit = 1'b1;
			idle_ev  = mk_ev(EV_CLOSE, CH_NUL);
		end else if (ch == CH_QUOTE) begin
			idle_st.mode = MODE_STRING;
			idle_st.bs   = 1'b0;
		end else if (ch == CH_SEMI) begin
			idle_st.mode = MODE_COMMENT;
		end else if (ch == CH_DOT) begin
			idle_st.dot = 1'b1;
		end else begin
			idle_hit     = 1'b1;
			idle_ev      = mk_ev(EV_ATOM_BYTE, ch);
			idle_st.mode = MODE_ATOM;
		end
	end

	always_comb begin
		nxt     = cur;
		evs.cnt = 2'd0;
		evs.ev0 = mk_ev(EV_OPEN, CH_NUL);
		evs.ev1 = mk_ev(EV_OPEN, CH_NUL);
		case (cur.mode)
			MODE_IDLE: begin
				if (cur.dot) begin
					if (is_blank || is_paren) begin
						nxt     = idle_st;
						evs.ev0 = mk_ev(EV_DOT, CH_NUL);
						evs.ev1 = idle_ev;
						evs.cnt = idle_hit ? 2'd2 : 2'd1;
					end else begin
						nxt.mode = MODE_ATOM;
						nxt.dot  = 1'b0;
						evs.ev0  = mk_ev(EV_ATOM_BYTE, CH_DOT);
						evs.ev1  = mk_ev(EV_ATOM_BYTE, ch);
						evs.cnt  = 2'd2;
					end
				end else begin
					nxt     = idle_st;
					evs.ev0 = idle_ev;
					evs.cnt = {1'b0, idle_hit};
				end
			end
			MODE_ATOM: begin
				if (is_blank || is_paren) begin
					nxt     = idle_st;
					evs.ev0 = mk_ev(EV_ATOM_END, CH_NUL);
					evs.ev1 = idle_ev;
					evs.cnt = idle_hit ? 2'd2 : 2'd1;
				end else begin
					evs.ev0 = mk_ev(EV_ATOM_BYTE, ch);
					evs.cnt = 2'd1;
				end
			end
			MODE_STRING: begin
				if (ch == CH_QUOTE && !cur.bs) begin
					nxt.mode = MODE_IDLE;
					evs.ev0  = mk_ev(EV_STR_END, CH_NUL);
				end else begin
					nxt.bs  = (ch == CH_BSLASH) && !cur.bs;
					evs.ev0 = mk_ev(EV_STR_BYTE, ch);
				end
				evs.cnt = 2'd1;
			end
			MODE_COMMENT: begin
				if (ch == CH_NL) begin
					nxt.mode = MODE_IDLE;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
		evs.ev0.last = (evs.cnt == 2'd1);
		evs.ev1.last = (evs.cnt == 2'd2);
	end

endmodule

FILE: hdl/stx_fifo.sv
module stx_fifo #(
	parameter int DEPTH = stx_pkg::FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stx_pkg::event_pair_t push,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output stx_pkg::event_t      out_ev
);
	import stx_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	event_t        mem [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] wr1;
	logic          pop;

	assign wr1       = inc(wr_q);
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q <= CW'(DEPTH - 2));
	assign out_ev    = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_q] <= push.ev0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr1] <= push.ev1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.cnt == 2'd1) begin
				wr_q <= wr1;
			end else if (push.cnt == 2'd2) begin
				wr_q <= inc(wr1);
			end
			if (pop) begin
				rd_q <= inc(rd_q);
			end
			cnt_q <= cnt_q + CW'(push.cnt) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("event queue overflow");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> room)
		else $error("push into full event queue");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_ev)))
		else $error("queued request changed while stalled");

endmodule

FILE: hdl/sexpr_tokenizer.sv
// An accepted byte is registered in the input stage, scanned, and its events
// are written into the event queue. Throughput: one byte per cycle while the
// queue has room for two events; the output passes one event per handshake.
// Zero bytes are accepted and dropped.
// Reset (arst_n low, asynchronous) returns the scanner to between-token state
// and empties the input stage and the event queue.
module sexpr_tokenizer #(
	parameter int FIFO_DEPTH = stx_pkg::FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_ready,
	input  logic [7:0] text_byte,
	output logic       event_valid,
	input  logic       event_ready,
	output logic [2:0] event_kind,
	output logic [7:0] event_byte,
	output logic       last_of_run
);
	import stx_pkg::*;

	logic        vld_s1;
	logic [7:0]  ch_s1;
	scan_state_t state_q;
	scan_state_t nxt;
	event_pair_t evs;
	event_pair_t push;
	event_t      out_ev;
	logic        room;
	logic        adv;

	assign adv        = vld_s1 && room;
	assign text_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (text_ready) begin
			vld_s1 <= text_valid && (text_byte != CH_NUL);
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && text_ready) begin
			ch_s1 <= text_byte;
		end
	end

	stx_scan u_scan (
		.ch  (ch_s1),
		.cur (state_q),
		.nxt (nxt),
		.evs (evs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode <= MODE_IDLE;
			state_q.dot  <= 1'b0;
			state_q.bs   <= 1'b0;
		end else if (adv) begin
			state_q <= nxt;
		end
	end

	// drop the request count when the stage does not advance
	always_comb begin
		push     = evs;
		push.cnt = adv ? evs.cnt : 2'd0;
	end

	stx_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (event_valid),
		.out_ready (event_ready),
		.out_ev    (out_ev)
	);

	assign event_kind  = out_ev.kind;
	assign event_byte  = out_ev.data;
	assign last_of_run = out_ev.last;

	a_dot_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.dot |-> (state_q.mode == MODE_IDLE))
		else $error("dot held outside idle mode");

	a_bs_only_string: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bs |-> (state_q.mode == MODE_STRING))
		else $error("escape flag set outside string");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> (vld_s1 && $stable(ch_s1) && $stable(state_q)))
		else $error("stalled byte lost or state moved");

endmodule
